[design/buzz_pkg.sv]
// ----------------------------------------------------------------------------
// buzz_pkg
// Types, codes and timing tables for the buzzer alert pattern sequencer.
// ----------------------------------------------------------------------------
package buzz_pkg;

  localparam int OP_W    = 3;
  localparam int VAL_W   = 8;
  localparam int FREQ_W  = 16;
  localparam int MS_W    = 32;
  localparam int PCT_W   = 7;
  localparam int DUR_W   = 10;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_MODE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_LEVEL = 3'd2;
  localparam logic [OP_W-1:0] OP_NEW_EVENT = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_PCT   = 3'd4;
  localparam logic [OP_W-1:0] OP_STOP_ALL  = 3'd5;

  // mode codes
  localparam logic [1:0] MODE_QUIET  = 2'd0;
  localparam logic [1:0] MODE_ACTIVE = 2'd1;
  localparam logic [1:0] MODE_DIAG   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_NEW_EVENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LEVEL_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LEVEL_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LEVEL_3A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_LEVEL_3B  = 3'd4;

  localparam logic [FREQ_W-1:0] RST_FREQ_NEW_EVENT = 16'd4000;
  localparam logic [FREQ_W-1:0] RST_FREQ_LEVEL_ONE = 16'd2000;
  localparam logic [FREQ_W-1:0] RST_FREQ_LEVEL_TWO = 16'd2500;
  localparam logic [FREQ_W-1:0] RST_FREQ_LEVEL_3A  = 16'd3000;
  localparam logic [FREQ_W-1:0] RST_FREQ_LEVEL_3B  = 16'd2000;

  localparam int CHIRP_MS      = 70;
  localparam int L2_ON_MS      = 120;
  localparam int L2_OFF_MS     = 80;
  localparam int L3_STEP_MS    = 150;
  localparam int DIAG_FULL_PCT = 85;
  localparam int DIAG_SLOW_MS  = 900;
  localparam int DIAG_FAST_MS  = 140;
  localparam int DIAG_MIN_PCT  = 5;
  localparam int MAX_LEVEL     = 3;
  localparam int MAX_PCT       = 100;
  localparam int PCT_ENTRIES   = 1 << PCT_W;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq;
    logic              tone_on;
  } result_t;

  typedef logic [DUR_W-1:0] dur_table_t [PCT_ENTRIES];

  function automatic int diag_period(int idx);
    int p;
    int period;
    p = (idx < DIAG_MIN_PCT) ? DIAG_MIN_PCT : idx;
    period = DIAG_SLOW_MS - ((DIAG_SLOW_MS - DIAG_FAST_MS) * p) / DIAG_FULL_PCT;
    if (period < DIAG_FAST_MS) period = DIAG_FAST_MS;
    if (period > DIAG_SLOW_MS) period = DIAG_SLOW_MS;
    return period;
  endfunction

  // on and off times of the diagnostic blink, one entry per percent value
  function automatic dur_table_t build_diag_on();
    dur_table_t t;
    for (int i = 0; i < PCT_ENTRIES; i++) begin
      t[i] = DUR_W'(diag_period(i) / 3);
    end
    return t;
  endfunction

  function automatic dur_table_t build_diag_off();
    dur_table_t t;
    for (int i = 0; i < PCT_ENTRIES; i++) begin
      t[i] = DUR_W'((diag_period(i) * 2) / 3);
    end
    return t;
  endfunction

  localparam dur_table_t DIAG_ON_MS  = build_diag_on();
  localparam dur_table_t DIAG_OFF_MS = build_diag_off();

endpackage

[design/buzzer_alert_pattern_sequencer_top.sv]
// ----------------------------------------------------------------------------
// buzzer_alert_pattern_sequencer_top
// Millisecond-tick buzzer pattern sequencer: picks the tone frequency.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one word per tick or
//   control event. tone channel (tone_valid / tone_stall / tone) returns one
//   word per accepted cmd word: the tone frequency now driven and tone_on.
//   cfg_we / cfg_index / cfg_data write the five frequency registers; write
//   them only while the block is idle.
// Timing:
//   One cmd word is accepted per cycle while cmd_stall is low. All state
//   updates in the accept cycle (a 32-bit subtract and compare per deadline,
//   a table lookup for the diagnostic blink times); the result sits in the
//   output register in the cycle after acceptance.
// Reset:
//   rst (synchronous) restores the default frequencies, silent mode, all
//   counters and deadlines to zero, and empties the output register.
// Back-pressure:
//   While tone_stall holds a full output register, cmd_stall is raised and
//   no new word is taken; the held word stays stable.
// ----------------------------------------------------------------------------
module buzzer_alert_pattern_sequencer_top
  import buzz_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 tone_valid,
  input  logic                 tone_stall,
  output result_t              tone,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data
);

  logic [FREQ_W-1:0] freq_new_event, freq_level_one, freq_level_two;
  logic [FREQ_W-1:0] freq_level_three_a, freq_level_three_b;

  logic [1:0]        mode_reg, mode_reg_next;
  logic [1:0]        run_level, run_level_next;
  logic [PCT_W-1:0]  diag_percent, diag_percent_next;
  logic [MS_W-1:0]   now_ms, now_ms_next;
  logic [MS_W-1:0]   run_deadline, run_deadline_next;
  logic              run_phase_on, run_phase_on_next;
  logic              run_alternate, run_alternate_next;
  logic [MS_W-1:0]   chirp_until, chirp_until_next;
  logic [MS_W-1:0]   diag_deadline, diag_deadline_next;
  logic              diag_phase_on, diag_phase_on_next;
  logic [FREQ_W-1:0] current_freq, current_freq_next;

  logic            accept;
  logic [MS_W-1:0] tick_ms;
  logic [MS_W-1:0] run_diff, chirp_diff, diag_diff;
  logic            run_due, diag_due, chirp_live;
  logic [DUR_W-1:0] diag_on_ms, diag_off_ms;

  assign cmd_stall = tone_valid & tone_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  // wrap-safe compares against the advanced counter
  assign tick_ms    = now_ms + MS_W'(1);
  assign run_diff   = tick_ms - run_deadline;
  assign chirp_diff = tick_ms - chirp_until;
  assign diag_diff  = tick_ms - diag_deadline;
  assign run_due    = (run_deadline == '0) | ~run_diff[MS_W-1];
  assign diag_due   = (diag_deadline == '0) | ~diag_diff[MS_W-1];
  assign chirp_live = (chirp_until != '0) & chirp_diff[MS_W-1];
  assign diag_on_ms  = DIAG_ON_MS[diag_percent];
  assign diag_off_ms = DIAG_OFF_MS[diag_percent];

  always_comb begin
    mode_reg_next      = mode_reg;
    run_level_next     = run_level;
    diag_percent_next  = diag_percent;
    now_ms_next        = now_ms;
    run_deadline_next  = run_deadline;
    run_phase_on_next  = run_phase_on;
    run_alternate_next = run_alternate;
    chirp_until_next   = chirp_until;
    diag_deadline_next = diag_deadline;
    diag_phase_on_next = diag_phase_on;
    current_freq_next  = current_freq;
    case (cmd.op)
      OP_TICK: begin
        now_ms_next = tick_ms;
        if (mode_reg == MODE_QUIET) begin
          current_freq_next = '0;
        end else if (mode_reg == MODE_ACTIVE) begin
          if (run_level == 2'd0) begin
            current_freq_next = '0;
          end else if (chirp_live) begin
            current_freq_next = freq_new_event;
          end else if (run_level == 2'd1) begin
            current_freq_next = freq_level_one;
          end else if (run_level == 2'd2) begin
            if (run_due) begin
              run_phase_on_next = ~run_phase_on;
              if (!run_phase_on) begin
                current_freq_next = freq_level_two;
                run_deadline_next = tick_ms + MS_W'(L2_ON_MS);
              end else begin
                current_freq_next = '0;
                run_deadline_next = tick_ms + MS_W'(L2_OFF_MS);
              end
            end
          end else if (run_due) begin
            run_alternate_next = ~run_alternate;
            current_freq_next  = run_alternate ? freq_level_three_b : freq_level_three_a;
            run_deadline_next  = tick_ms + MS_W'(L3_STEP_MS);
          end
        end else begin
          if (diag_percent >= PCT_W'(DIAG_FULL_PCT)) begin
            current_freq_next  = freq_level_two;
            diag_deadline_next = '0;
            diag_phase_on_next = 1'b1;
          end else if (diag_due) begin
            diag_phase_on_next = ~diag_phase_on;
            if (!diag_phase_on) begin
              current_freq_next  = freq_level_two;
              diag_deadline_next = tick_ms + MS_W'(diag_on_ms);
            end else begin
              current_freq_next  = '0;
              diag_deadline_next = tick_ms + MS_W'(diag_off_ms);
            end
          end
        end
      end
      OP_SET_MODE: begin
        if (cmd.value <= VAL_W'(MODE_DIAG) && cmd.value != VAL_W'(mode_reg)) begin
          mode_reg_next      = cmd.value[1:0];
          run_deadline_next  = '0;
          run_phase_on_next  = 1'b0;
          run_alternate_next = 1'b0;
          diag_deadline_next = '0;
          diag_phase_on_next = 1'b0;
          if (cmd.value[1:0] == MODE_QUIET) current_freq_next = '0;
        end
      end
      OP_SET_LEVEL: begin
        run_level_next = (cmd.value > VAL_W'(MAX_LEVEL)) ? 2'(MAX_LEVEL) : cmd.value[1:0];
      end
      OP_NEW_EVENT: begin
        chirp_until_next = now_ms + MS_W'(CHIRP_MS);
      end
      OP_SET_PCT: begin
        diag_percent_next = (cmd.value > VAL_W'(MAX_PCT)) ? PCT_W'(MAX_PCT)
                                                          : cmd.value[PCT_W-1:0];
      end
      OP_STOP_ALL: begin
        run_level_next     = '0;
        chirp_until_next   = '0;
        diag_percent_next  = '0;
        diag_deadline_next = '0;
        diag_phase_on_next = 1'b0;
        current_freq_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_new_event     <= RST_FREQ_NEW_EVENT;
      freq_level_one     <= RST_FREQ_LEVEL_ONE;
      freq_level_two     <= RST_FREQ_LEVEL_TWO;
      freq_level_three_a <= RST_FREQ_LEVEL_3A;
      freq_level_three_b <= RST_FREQ_LEVEL_3B;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FREQ_NEW_EVENT: freq_new_event     <= cfg_data;
        REG_FREQ_LEVEL_ONE: freq_level_one     <= cfg_data;
        REG_FREQ_LEVEL_TWO: freq_level_two     <= cfg_data;
        REG_FREQ_LEVEL_3A:  freq_level_three_a <= cfg_data;
        REG_FREQ_LEVEL_3B:  freq_level_three_b <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_QUIET;
      run_level     <= '0;
      diag_percent  <= '0;
      now_ms        <= '0;
      run_deadline  <= '0;
      run_phase_on  <= 1'b0;
      run_alternate <= 1'b0;
      chirp_until   <= '0;
      diag_deadline <= '0;
      diag_phase_on <= 1'b0;
      current_freq  <= '0;
    end else if (accept) begin
      mode_reg      <= mode_reg_next;
      run_level     <= run_level_next;
      diag_percent  <= diag_percent_next;
      now_ms        <= now_ms_next;
      run_deadline  <= run_deadline_next;
      run_phase_on  <= run_phase_on_next;
      run_alternate <= run_alternate_next;
      chirp_until   <= chirp_until_next;
      diag_deadline <= diag_deadline_next;
      diag_phase_on <= diag_phase_on_next;
      current_freq  <= current_freq_next;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_valid <= 1'b0;
    end else if (accept) begin
      tone_valid <= 1'b1;
    end else if (!tone_stall) begin
      tone_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tone.tone_freq <= current_freq_next;
      tone.tone_on   <= (current_freq_next != '0);
    end
  end

endmodule

[tb/tb_buzzer_alert_pattern_sequencer_top.sv]
// ----------------------------------------------------------------------------
// tb_buzzer_alert_pattern_sequencer_top
// Self-checking bench for the buzzer pattern sequencer. A tone model follows
// every accepted cmd word (ticks and control events) and queues the tone
// word it should produce; each returned tone word is checked against it.
// After a short directed run on the reset frequencies, random sequences of
// mode, level, percent and chirp events followed by runs of ticks are sent
// under three frequency settings and three patterns of idling and stalls.
// ----------------------------------------------------------------------------
module tb_buzzer_alert_pattern_sequencer_top;
  import buzz_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int T_CHIRP        = 70;
  localparam int T_L2_ON        = 120;
  localparam int T_L2_OFF       = 80;
  localparam int T_L3_STEP      = 150;
  localparam int DIAG_SOLID_PCT = 85;
  localparam int DIAG_LOW_PCT   = 5;
  localparam int DIAG_SLOWEST   = 900;
  localparam int DIAG_FASTEST   = 140;
  localparam int TOP_LEVEL      = 3;
  localparam int TOP_PCT        = 100;
  localparam int N_FREQ_REGS    = 5;

  bit                   clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_stall;
  cmd_t                 cmd;
  logic                 tone_valid;
  logic                 tone_stall;
  result_t              tone;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FREQ_W-1:0]    cfg_data;

  int send_pct;
  int recv_pct;
  int words_sent;

  // tone model plus the queue of tone words still owed by the block
  class tone_model;
    logic [FREQ_W-1:0] freq [N_FREQ_REGS];
    logic [1:0]        mode;
    logic [1:0]        level;
    logic [PCT_W-1:0]  pct;
    logic [MS_W-1:0]   now_ms;
    logic [MS_W-1:0]   run_due;
    logic [MS_W-1:0]   chirp_end;
    logic [MS_W-1:0]   diag_due;
    bit                run_on;
    bit                run_alt;
    bit                diag_on;
    logic [FREQ_W-1:0] tone_now;
    result_t           tones_due [$];
    int                errors;

    function new();
      freq[REG_FREQ_NEW_EVENT] = 16'd4000;
      freq[REG_FREQ_LEVEL_ONE] = 16'd2000;
      freq[REG_FREQ_LEVEL_TWO] = 16'd2500;
      freq[REG_FREQ_LEVEL_3A]  = 16'd3000;
      freq[REG_FREQ_LEVEL_3B]  = 16'd2000;
      mode      = MODE_QUIET;
      level     = '0;
      pct       = '0;
      now_ms    = '0;
      run_due   = '0;
      chirp_end = '0;
      diag_due  = '0;
      run_on    = 1'b0;
      run_alt   = 1'b0;
      diag_on   = 1'b0;
      tone_now  = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [FREQ_W-1:0] d);
      if (idx <= REG_FREQ_LEVEL_3B) freq[idx] = d;
    endfunction

    // wrap-safe: a zero deadline is always due
    function bit is_due(logic [MS_W-1:0] dl);
      logic [MS_W-1:0] lag;
      lag = now_ms - dl;
      return (dl == '0) || !lag[MS_W-1];
    endfunction

    function void tick_run();
      logic [MS_W-1:0] lag;
      lag = now_ms - chirp_end;
      if (level == 2'd0) begin
        tone_now = '0;
      end else if (chirp_end != '0 && lag[MS_W-1]) begin
        tone_now = freq[REG_FREQ_NEW_EVENT];
      end else if (level == 2'd1) begin
        tone_now = freq[REG_FREQ_LEVEL_ONE];
      end else if (level == 2'd2) begin
        if (is_due(run_due)) begin
          run_on = !run_on;
          if (run_on) begin
            tone_now = freq[REG_FREQ_LEVEL_TWO];
            run_due  = now_ms + T_L2_ON;
          end else begin
            tone_now = '0;
            run_due  = now_ms + T_L2_OFF;
          end
        end
      end else if (is_due(run_due)) begin
        run_alt  = !run_alt;
        tone_now = run_alt ? freq[REG_FREQ_LEVEL_3A] : freq[REG_FREQ_LEVEL_3B];
        run_due  = now_ms + T_L3_STEP;
      end
    endfunction

    function void tick_diag();
      int p;
      int period;
      if (pct >= DIAG_SOLID_PCT) begin
        tone_now = freq[REG_FREQ_LEVEL_TWO];
        diag_due = '0;
        diag_on  = 1'b1;
        return;
      end
      p = (pct < DIAG_LOW_PCT) ? DIAG_LOW_PCT : int'(pct);
      period = DIAG_SLOWEST - ((DIAG_SLOWEST - DIAG_FASTEST) * p) / DIAG_SOLID_PCT;
      if (period < DIAG_FASTEST) period = DIAG_FASTEST;
      if (period > DIAG_SLOWEST) period = DIAG_SLOWEST;
      if (is_due(diag_due)) begin
        diag_on = !diag_on;
        if (diag_on) begin
          tone_now = freq[REG_FREQ_LEVEL_TWO];
          diag_due = now_ms + MS_W'(period / 3);
        end else begin
          tone_now = '0;
          diag_due = now_ms + MS_W'((period * 2) / 3);
        end
      end
    endfunction

    function void note_cmd(cmd_t c);
      result_t r;
      case (c.op)
        OP_TICK: begin
          now_ms = now_ms + 1;
          if (mode == MODE_QUIET) tone_now = '0;
          else if (mode == MODE_ACTIVE) tick_run();
          else tick_diag();
        end
        OP_SET_MODE: begin
          if (c.value <= VAL_W'(MODE_DIAG) && c.value[1:0] != mode) begin
            mode     = c.value[1:0];
            run_due  = '0;
            run_on   = 1'b0;
            run_alt  = 1'b0;
            diag_due = '0;
            diag_on  = 1'b0;
            if (mode == MODE_QUIET) tone_now = '0;
          end
        end
        OP_SET_LEVEL: level = (c.value > TOP_LEVEL) ? 2'(TOP_LEVEL) : c.value[1:0];
        OP_NEW_EVENT: chirp_end = now_ms + T_CHIRP;
        OP_SET_PCT:   pct = (c.value > TOP_PCT) ? PCT_W'(TOP_PCT) : c.value[PCT_W-1:0];
        OP_STOP_ALL: begin
          level     = '0;
          chirp_end = '0;
          pct       = '0;
          diag_due  = '0;
          diag_on   = 1'b0;
          tone_now  = '0;
        end
        default: ;
      endcase
      r.tone_freq = tone_now;
      r.tone_on   = (tone_now != '0);
      tones_due.push_back(r);
    endfunction

    function void check_tone(result_t got);
      result_t want;
      if (tones_due.size() == 0) begin
        errors++;
        $display("%0t: tone word with none owed: expected none actual freq %0d on %0b",
                 $time, got.tone_freq, got.tone_on);
        return;
      end
      want = tones_due.pop_front();
      if (got.tone_freq !== want.tone_freq) begin
        errors++;
        $display("%0t: tone_freq expected %0d actual %0d",
                 $time, want.tone_freq, got.tone_freq);
      end
      if (got.tone_on !== want.tone_on) begin
        errors++;
        $display("%0t: tone_on expected %0b actual %0b", $time, want.tone_on, got.tone_on);
      end
    endfunction
  endclass

  tone_model model = new();

  buzzer_alert_pattern_sequencer_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .tone_valid (tone_valid),
    .tone_stall (tone_stall),
    .tone       (tone),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    tone_stall <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && tone_valid && !tone_stall) model.check_tone(tone);
  end

  // entered and left at a falling edge; valid stays high into the next word
  task automatic send(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value);
    cmd_t c;
    c.op    = op;
    c.value = value;
    while ($urandom_range(99) < send_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    model.note_cmd(c);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (model.tones_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_freqs(input logic [FREQ_W-1:0] f0, f1, f2, f3, f4);
    logic [FREQ_W-1:0] vals [N_FREQ_REGS];
    vals = '{f0, f1, f2, f3, f4};
    for (int i = 0; i < N_FREQ_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      model.write_reg(CFG_IDX_W'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // set-up words with random content, then a run of ticks with the odd
  // control word dropped in
  task automatic pattern_burst();
    int n;
    int r;
    r = $urandom_range(99);
    if (r < 90) send(OP_SET_MODE, VAL_W'($urandom_range(0, 2)));
    else send(OP_SET_MODE, VAL_W'($urandom_range(3, 255)));
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(99) < 85) send(OP_SET_LEVEL, VAL_W'($urandom_range(0, 3)));
      else send(OP_SET_LEVEL, VAL_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 45) send(OP_SET_PCT, VAL_W'($urandom_range(0, 84)));
      else if (r < 65) send(OP_SET_PCT, VAL_W'($urandom_range(85, 100)));
      else if (r < 80) send(OP_SET_PCT, VAL_W'($urandom_range(60, 84)));
      else send(OP_SET_PCT, VAL_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(99) < 40) send(OP_NEW_EVENT, VAL_W'($urandom_range(0, 255)));
    n = ($urandom_range(99) < 10) ? $urandom_range(250, 450) : $urandom_range(1, 160);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3)
        send(OP_W'($urandom_range(1, 7)), VAL_W'($urandom_range(0, 255)));
      send(OP_TICK, VAL_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input int goal);
    int start;
    start = words_sent;
    while (words_sent - start < goal) begin
      if ($urandom_range(99) < 80) begin
        pattern_burst();
      end else begin
        repeat ($urandom_range(1, 8))
          send(OP_W'($urandom_range(0, 7)), VAL_W'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    tone_stall = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    send_pct   = 0;
    recv_pct   = 0;
    words_sent = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed, on the reset frequencies
    send(OP_TICK, 8'd0);
    send(OP_SET_MODE, 8'd9);                  // unknown mode, ignored
    send(OP_SET_MODE, VAL_W'(MODE_ACTIVE));
    send(OP_TICK, 8'd255);
    send(OP_SET_LEVEL, 8'd1);
    send(OP_TICK, 8'd0);
    send(OP_NEW_EVENT, 8'd0);
    send(OP_TICK, 8'd0);                      // chirp wins over level one
    send(OP_STOP_ALL, 8'd255);
    send(OP_SET_LEVEL, 8'd2);
    send(OP_TICK, 8'd0);
    send(OP_SET_LEVEL, 8'd255);               // saturates at three
    send(OP_TICK, 8'd0);
    send(OP_SET_MODE, VAL_W'(MODE_ACTIVE));   // same mode, no phase reset
    send(OP_SET_MODE, VAL_W'(MODE_DIAG));
    send(OP_SET_PCT, 8'd255);                 // saturates at 100
    send(OP_TICK, 8'd0);
    send(OP_SET_PCT, 8'd0);                   // slowest blink
    send(OP_TICK, 8'd0);
    send(OP_SPARE_6, 8'hAA);
    send(OP_SPARE_7, 8'h55);
    send(OP_SET_MODE, VAL_W'(MODE_QUIET));
    send(OP_SET_MODE, VAL_W'(MODE_ACTIVE));
    send(OP_TICK, 8'd0);
    send(OP_STOP_ALL, 8'd0);
    drain();

    program_freqs(FREQ_W'($urandom_range(0, 65535)), FREQ_W'($urandom_range(0, 65535)),
                  FREQ_W'($urandom_range(0, 65535)), FREQ_W'($urandom_range(0, 65535)),
                  FREQ_W'($urandom_range(0, 65535)));
    send_pct = 8;
    recv_pct = 61;
    random_phase(210);
    drain();

    program_freqs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFE);
    send_pct = 61;
    recv_pct = 8;
    random_phase(210);
    drain();

    // zero frequencies must read back as silence
    program_freqs(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_pct = 0;
    recv_pct = 0;
    random_phase(210);
    drain();

    if (model.errors == 0) begin
      $display("tb_buzzer_alert_pattern_sequencer_top passed");
    end else begin
      $display("tb_buzzer_alert_pattern_sequencer_top failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_buzzer_alert_pattern_sequencer_top failed");
    $finish;
  end

endmodule
